// ===== src/sp2r_pkg.sv =====
package sp2r_pkg;

    localparam int VALUE_W   = 64;
    localparam int FRAC_W    = 52;
    localparam int EXPF_W    = 11;
    localparam int MANT_W    = FRAC_W + 1;
    localparam int TOP_BIT   = 52;
    localparam int EXP_W     = 12;
    localparam int CNT_W     = 5;
    localparam int RUN_W     = 6;
    localparam int BIT_W     = 6;
    localparam int EXP_BIAS  = 1023;
    localparam int MAX_TERMS = 27;

    // datapath operation selected by the current control word
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_PUSH_ZERO,
        OP_SHIFT,
        OP_EMIT_PLUS,
        OP_EMIT_SECOND,
        OP_CLR_RUN,
        OP_PUSH_LAST
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_ZERO_IN,
        COND_RUN_END,
        COND_SCAN_LAST,
        COND_CAP,
        COND_SECOND,
        COND_END
    } cond_t;

    // program addresses
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_ZERO,
        STEP_SCAN,
        STEP_EMIT_A,
        STEP_EMIT_B,
        STEP_RESUME,
        STEP_FLUSH
    } step_t;

    typedef struct packed {
        op_t op;
    } ctl_t;

    typedef struct packed {
        logic op_done;
        logic zero_in;
        logic run_end;
        logic scan_last;
        logic cap;
        logic second;
        logic scan_end;
    } status_t;

endpackage

// ===== src/sp2r_if.sv =====
interface sp2r_in_if;
    logic                             valid;
    logic                             ready;
    logic [sp2r_pkg::VALUE_W-1:0]     value_bits;

    modport source (output valid, output value_bits, input ready);
    modport sink   (input valid, input value_bits, output ready);
endinterface

interface sp2r_out_if;
    logic                             valid;
    logic                             ready;
    logic                             term_valid;
    logic                             term_sign;
    logic signed [sp2r_pkg::EXP_W-1:0] term_exponent;
    logic [sp2r_pkg::CNT_W-1:0]       term_count;
    logic                             last_term;

    modport source (output valid, output term_valid, output term_sign,
                    output term_exponent, output term_count, output last_term,
                    input ready);
    modport sink   (input valid, input term_valid, input term_sign,
                    input term_exponent, input term_count, input last_term,
                    output ready);
endinterface

// ===== src/sp2r_seq.sv =====
module sp2r_seq
    import sp2r_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctl_t    ctl
);

    typedef struct packed {
        op_t   op;
        cond_t c1;
        step_t t1;
        cond_t c2;
        step_t t2;
        step_t tdef;
    } ucode_t;

    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        unique case (s)
            STEP_IDLE:   w = '{OP_LOAD,        COND_ZERO_IN,   STEP_ZERO,
                               COND_NEVER,     STEP_IDLE,      STEP_SCAN};
            STEP_ZERO:   w = '{OP_PUSH_ZERO,   COND_ALWAYS,    STEP_IDLE,
                               COND_NEVER,     STEP_IDLE,      STEP_IDLE};
            STEP_SCAN:   w = '{OP_SHIFT,       COND_RUN_END,   STEP_EMIT_A,
                               COND_SCAN_LAST, STEP_FLUSH,     STEP_SCAN};
            STEP_EMIT_A: w = '{OP_EMIT_PLUS,   COND_CAP,       STEP_FLUSH,
                               COND_SECOND,    STEP_EMIT_B,    STEP_RESUME};
            STEP_EMIT_B: w = '{OP_EMIT_SECOND, COND_CAP,       STEP_FLUSH,
                               COND_NEVER,     STEP_IDLE,      STEP_RESUME};
            STEP_RESUME: w = '{OP_CLR_RUN,     COND_END,       STEP_FLUSH,
                               COND_NEVER,     STEP_IDLE,      STEP_SCAN};
            STEP_FLUSH:  w = '{OP_PUSH_LAST,   COND_ALWAYS,    STEP_IDLE,
                               COND_NEVER,     STEP_IDLE,      STEP_IDLE};
            default:     w = '{OP_CLR_RUN,     COND_ALWAYS,    STEP_IDLE,
                               COND_NEVER,     STEP_IDLE,      STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic cond_hit(cond_t c, status_t s);
        logic hit;
        unique case (c)
            COND_NEVER:     hit = 1'b0;
            COND_ALWAYS:    hit = 1'b1;
            COND_ZERO_IN:   hit = s.zero_in;
            COND_RUN_END:   hit = s.run_end;
            COND_SCAN_LAST: hit = s.scan_last;
            COND_CAP:       hit = s.cap;
            COND_SECOND:    hit = s.second;
            COND_END:       hit = s.scan_end;
            default:        hit = 1'b0;
        endcase
        return hit;
    endfunction

    step_t  step_reg;
    step_t  step_next;
    ucode_t uc;

    assign uc = ucode_rom(step_reg);

    always_comb
    begin
        step_next = step_reg;
        if (status.op_done)
        begin
            priority if (cond_hit(uc.c1, status))
                step_next = uc.t1;
            else if (cond_hit(uc.c2, status))
                step_next = uc.t2;
            else
                step_next = uc.tdef;
        end
    end

    always_comb
    begin
        ctl.op = uc.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

// ===== src/sp2r_dp.sv =====
module sp2r_dp
    import sp2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sp2r_in_if.sink    in_ch,
    sp2r_out_if.source out_ch,
    input  ctl_t       ctl,
    output status_t    status
);

    logic [MANT_W-1:0] sh_reg,        sh_next;
    logic [BIT_W-1:0]  bit_reg,       bit_next;
    logic [EXP_W-1:0]  ex_reg,        ex_next;
    logic [EXP_W-1:0]  top_reg,       top_next;
    logic              sgn_reg,       sgn_next;
    logic [RUN_W-1:0]  run_reg,       run_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic              end_reg,       end_next;
    logic              tail_reg,      tail_next;
    logic              pend_vld_reg,  pend_vld_next;
    logic              pend_sign_reg, pend_sign_next;
    logic [EXP_W-1:0]  pend_exp_reg,  pend_exp_next;
    logic [CNT_W-1:0]  pend_cnt_reg,  pend_cnt_next;
    logic              out_vld_reg,   out_vld_next;
    logic              out_tv_reg,    out_tv_next;
    logic              out_sign_reg,  out_sign_next;
    logic [EXP_W-1:0]  out_exp_reg,   out_exp_next;
    logic [CNT_W-1:0]  out_cnt_reg,   out_cnt_next;
    logic              out_last_reg,  out_last_next;

    logic              cur_bit;
    logic              run_gt0;
    logic              big_run;
    logic              out_free;
    logic              emit_ok;
    logic              op_done;
    logic              in_ready;
    logic [EXP_W-1:0]  plus_exp;
    logic [EXP_W-1:0]  sec_exp;
    logic              new_sign;
    logic [EXP_W-1:0]  new_exp;

    assign cur_bit  = sh_reg[MANT_W-1];
    assign run_gt0  = (run_reg != '0);
    assign big_run  = (run_reg >= RUN_W'(3));
    assign out_free = !out_vld_reg || out_ch.ready;
    assign emit_ok  = !pend_vld_reg || out_free;
    // run of three or more: +2^(top+1) and -2^(lowest bit of run);
    // run of two: the second one-bit alone, which lands on the same weight
    assign plus_exp = top_reg + (big_run ? EXP_W'(1) : EXP_W'(0));
    assign sec_exp  = top_reg - EXP_W'(run_reg) + EXP_W'(1);

    always_comb
    begin
        sh_next        = sh_reg;
        bit_next       = bit_reg;
        ex_next        = ex_reg;
        top_next       = top_reg;
        sgn_next       = sgn_reg;
        run_next       = run_reg;
        cnt_next       = cnt_reg;
        end_next       = end_reg;
        tail_next      = tail_reg;
        pend_vld_next  = pend_vld_reg;
        pend_sign_next = pend_sign_reg;
        pend_exp_next  = pend_exp_reg;
        pend_cnt_next  = pend_cnt_reg;
        out_vld_next   = out_ch.ready ? 1'b0 : out_vld_reg;
        out_tv_next    = out_tv_reg;
        out_sign_next  = out_sign_reg;
        out_exp_next   = out_exp_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        op_done        = 1'b1;
        in_ready       = 1'b0;
        new_sign       = sgn_reg;
        new_exp        = plus_exp;

        unique case (ctl.op)
            OP_LOAD:
            begin
                in_ready = 1'b1;
                op_done  = in_ch.valid;
                if (in_ch.valid)
                begin
                    sh_next       = {1'b1, in_ch.value_bits[FRAC_W-1:0]};
                    bit_next      = BIT_W'(TOP_BIT);
                    ex_next       = EXP_W'(in_ch.value_bits[VALUE_W-2 -: EXPF_W])
                                    - EXP_W'(EXP_BIAS);
                    sgn_next      = in_ch.value_bits[VALUE_W-1];
                    run_next      = '0;
                    cnt_next      = '0;
                    end_next      = 1'b0;
                    tail_next     = 1'b0;
                    pend_vld_next = 1'b0;
                end
            end
            OP_PUSH_ZERO:
            begin
                op_done = out_free;
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_tv_next   = 1'b0;
                    out_sign_next = 1'b0;
                    out_exp_next  = '0;
                    out_cnt_next  = '0;
                    out_last_next = 1'b1;
                end
            end
            OP_SHIFT:
            begin
                sh_next  = {sh_reg[MANT_W-2:0], 1'b0};
                bit_next = bit_reg - BIT_W'(1);
                ex_next  = ex_reg - EXP_W'(1);
                end_next = (bit_reg == '0);
                // a one-bit alone at bit 0 starts nothing
                if (cur_bit && (run_gt0 || bit_reg != '0))
                begin
                    run_next = run_reg + RUN_W'(1);
                    if (!run_gt0)
                        top_next = ex_reg;
                end
                tail_next = cur_bit && run_gt0 && (bit_reg == '0);
            end
            OP_EMIT_PLUS, OP_EMIT_SECOND:
            begin
                if (ctl.op == OP_EMIT_SECOND)
                begin
                    new_sign = big_run ? ~sgn_reg : sgn_reg;
                    new_exp  = sec_exp;
                end
                op_done = emit_ok;
                if (emit_ok)
                begin
                    if (pend_vld_reg)
                    begin
                        out_vld_next  = 1'b1;
                        out_tv_next   = 1'b1;
                        out_sign_next = pend_sign_reg;
                        out_exp_next  = pend_exp_reg;
                        out_cnt_next  = pend_cnt_reg;
                        out_last_next = 1'b0;
                    end
                    pend_vld_next  = 1'b1;
                    pend_sign_next = new_sign;
                    pend_exp_next  = new_exp;
                    pend_cnt_next  = cnt_reg + CNT_W'(1);
                    cnt_next       = cnt_reg + CNT_W'(1);
                end
            end
            OP_CLR_RUN:
            begin
                run_next = '0;
            end
            OP_PUSH_LAST:
            begin
                op_done = out_free;
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_tv_next   = 1'b1;
                    out_sign_next = pend_sign_reg;
                    out_exp_next  = pend_exp_reg;
                    out_cnt_next  = pend_cnt_reg;
                    out_last_next = 1'b1;
                    pend_vld_next = 1'b0;
                end
            end
            default:
            begin
                op_done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= '0;
            cnt_reg      <= '0;
            end_reg      <= 1'b0;
            tail_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            run_reg      <= run_next;
            cnt_reg      <= cnt_next;
            end_reg      <= end_next;
            tail_reg     <= tail_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg        <= sh_next;
        bit_reg       <= bit_next;
        ex_reg        <= ex_next;
        top_reg       <= top_next;
        sgn_reg       <= sgn_next;
        pend_sign_reg <= pend_sign_next;
        pend_exp_reg  <= pend_exp_next;
        pend_cnt_reg  <= pend_cnt_next;
        out_tv_reg    <= out_tv_next;
        out_sign_reg  <= out_sign_next;
        out_exp_reg   <= out_exp_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
    end

    assign in_ch.ready          = in_ready;
    assign out_ch.valid         = out_vld_reg;
    assign out_ch.term_valid    = out_tv_reg;
    assign out_ch.term_sign     = out_sign_reg;
    assign out_ch.term_exponent = out_exp_reg;
    assign out_ch.term_count    = out_cnt_reg;
    assign out_ch.last_term     = out_last_reg;

    assign status.op_done   = op_done;
    assign status.zero_in   = (in_ch.value_bits == '0);
    assign status.run_end   = run_gt0 && (!cur_bit || bit_reg == '0);
    assign status.scan_last = (bit_reg == '0);
    assign status.cap       = (cnt_reg == CNT_W'(MAX_TERMS - 1));
    assign status.second    = (run_reg >= RUN_W'(2)) && !tail_reg;
    assign status.scan_end  = end_reg;

endmodule

// ===== src/signed_power_of_two_recoder_core.sv =====
// Recodes the bit pattern of a double into signed power-of-two terms, one
// output item per term, the last marked by last_term. A small microcode
// program steps a datapath that scans the mantissa one bit per cycle from
// bit 52 down to bit 0; each run of ones costs one or two emit steps and
// one resume step, and the last term is held back one item so that it can
// be flagged. The scan ends early when the 27-term limit is reached, and
// the emit and flush steps wait while the output stalls. The all-zero
// pattern gives a single item with no term. One item is worked on at a
// time; input is taken again once the previous item's final term has
// reached the output register.
module signed_power_of_two_recoder_core
    import sp2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sp2r_in_if.sink    in_ch,
    sp2r_out_if.source out_ch
);

    ctl_t    ctl;
    status_t status;

    sp2r_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    sp2r_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .ctl    (ctl),
        .status (status)
    );

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> ctl.op != OP_LOAD)
        else $error("sequencer stayed idle after taking an item");

    a_cap_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_EMIT_PLUS || ctl.op == OP_EMIT_SECOND)
        && status.cap && status.op_done |=> ctl.op == OP_PUSH_LAST)
        else $error("term limit reached without final flush");

    a_zero_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.term_valid
        |-> out_ch.last_term && out_ch.term_count == '0)
        else $error("no-term item not final or with non-zero count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.term_valid
        |-> out_ch.term_count != '0 && out_ch.term_count <= CNT_W'(MAX_TERMS))
        else $error("term count out of range");

endmodule

// ===== sim/tb_signed_power_of_two_recoder_core.sv =====
module tb_signed_power_of_two_recoder_core
    import sp2r_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic                    has_term;
        logic                    minus;
        logic signed [EXP_W-1:0] expo;
        logic [CNT_W-1:0]        count;
        logic                    fin;
    } term_t;

    logic clk;
    logic rst_n;

    sp2r_in_if  in_ch ();
    sp2r_out_if out_ch ();

    signed_power_of_two_recoder_core u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    term_t terms_due[$];
    term_t pending[$];
    int    errors;
    int    values_sent;
    int    zero_values;
    int    capped_values;
    int    terms_seen;
    int    cycles;
    bit    burst;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d terms outstanding", cycles, terms_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void add_term(input logic neg, input int ex);
        term_t t;
        if (pending.size() < MAX_TERMS)
        begin
            t.has_term = 1'b1;
            t.minus    = neg;
            t.expo     = ex[EXP_W-1:0];
            t.count    = CNT_W'(pending.size() + 1);
            t.fin      = 1'b0;
            pending.push_back(t);
        end
    endfunction

    // signed-digit recoding of one double pattern into expected terms
    function automatic void recode_value(input logic [VALUE_W-1:0] v);
        logic [MANT_W-1:0] mant;
        logic              neg;
        int                ex;
        int                pos;
        int                len;
        term_t             t;
        pending.delete();
        if (v == '0)
        begin
            t = '{1'b0, 1'b0, '0, '0, 1'b1};
            pending.push_back(t);
            zero_values++;
        end
        else
        begin
            mant = {1'b1, v[FRAC_W-1:0]};
            neg  = v[VALUE_W-1];
            ex   = int'(v[VALUE_W-2:FRAC_W]) - EXP_BIAS;
            pos  = TOP_BIT;
            while (pos > 0)
            begin
                if (mant[pos])
                begin
                    len = 1;
                    while (len <= pos && mant[pos-len])
                        len++;
                    if (len > 2)
                    begin
                        add_term(neg, ex + 1);
                        if (len != pos + 1)
                            add_term(!neg, ex + 1 - len);
                        ex  -= len - 1;
                        pos -= len - 1;
                    end
                    else
                        add_term(neg, ex);
                end
                ex--;
                pos--;
            end
            pending[pending.size()-1].fin = 1'b1;
            if (pending.size() == MAX_TERMS)
                capped_values++;
        end
        foreach (pending[k])
            terms_due.push_back(pending[k]);
    endfunction

    // called at a rising edge; returns at the edge the item is taken
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value_bits <= v;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        recode_value(v);
        values_sent++;
    endtask

    initial
    begin
        term_t want;
        term_t got;
        int    stall;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, 5);
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            got = '{out_ch.term_valid, out_ch.term_sign, out_ch.term_exponent,
                    out_ch.term_count, out_ch.last_term};
            terms_seen++;
            if (terms_due.size() == 0)
            begin
                $display("%0t: unexpected term valid=%0b sign=%0b exp=%0d count=%0d last=%0b",
                         $time, got.has_term, got.minus, got.expo, got.count, got.fin);
                errors++;
            end
            else
            begin
                want = terms_due.pop_front();
                if (got !== want)
                begin
                    $display({"%0t: term mismatch, expected valid=%0b sign=%0b exp=%0d ",
                              "count=%0d last=%0b, got valid=%0b sign=%0b exp=%0d ",
                              "count=%0d last=%0b"},
                             $time, want.has_term, want.minus, want.expo, want.count,
                             want.fin, got.has_term, got.minus, got.expo, got.count,
                             got.fin);
                    errors++;
                end
            end
        end
    end

    task automatic test_zero_patterns();
        send_value(64'h0000_0000_0000_0000);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h0000_0000_0000_0000);
    endtask

    task automatic test_exponent_extremes();
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'h0000_0000_0000_0001);
        send_value(64'h000F_FFFF_FFFF_FFFF);
        send_value(64'h7FF0_0000_0000_0000);
        send_value(64'hFFF8_0000_0000_0000);
        send_value(64'h3FF0_0000_0000_0000);
    endtask

    task automatic test_run_shapes();
        send_value(64'h3FF8_0000_0000_0000);
        send_value(64'hBFFC_0000_0000_0000);
        send_value(64'hBFFF_FFFF_FFFF_FFFE);
        send_value(64'h3FF0_0000_0000_0007);
        send_value(64'h3FF0_0000_0000_0003);
        send_value(64'h4027_7777_7777_7776);
    endtask

    task automatic test_term_limit();
        send_value(64'h3FFB_6DB6_DB6D_B6DB);
        send_value(64'hC015_5555_5555_5555);
        send_value(64'h000B_6DB6_DB6D_B6DA);
    endtask

    // mostly run-structured mantissas, some raw patterns, zeros and exponent extremes
    task automatic test_random_values(input int n);
        logic [VALUE_W-1:0] v;
        logic [FRAC_W-1:0]  frac;
        int                 pos;
        int                 ones;
        for (int k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            frac = '0;
            pos  = FRAC_W - 1 - $urandom_range(0, 3);
            while (pos >= 0)
            begin
                ones = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 24 : 5);
                for (int b = 0; b < ones && pos >= 0; b++)
                begin
                    frac[pos] = 1'b1;
                    pos--;
                end
                pos -= $urandom_range(1, 3);
            end
            v = {$urandom_range(0, 1) == 1, 11'($urandom_range(0, 2047)), frac};
            case ($urandom_range(0, 9))
                0: v = {$urandom, $urandom};
                1: v = '0;
                2: v[VALUE_W-2:FRAC_W] = $urandom_range(0, 1) ? '1 : '0;
                default: ;
            endcase
            send_value(v);
        end
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.value_bits <= '0;
        errors           = 0;
        values_sent      = 0;
        zero_values      = 0;
        capped_values    = 0;
        terms_seen       = 0;
        cycles           <= 0;
        burst            = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_patterns();
        test_exponent_extremes();
        burst = 1'b1;
        test_run_shapes();
        burst = 1'b0;
        test_term_limit();
        test_random_values(141);

        @(posedge clk);
        in_ch.valid <= 1'b0;
        while (terms_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("recoded %0d values (%0d zero patterns, %0d hitting the term cap)",
                 values_sent, zero_values, capped_values);
        $display("checked %0d terms with %0d mismatches", terms_seen, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
